@@ hw/rtl/hpe_pkg.sv @@
// ----------------------------------------------------------------------------
// hpe_pkg
// Shared constants, types and helpers for the Horner polynomial evaluator.
// ----------------------------------------------------------------------------
package hpe_pkg;

    localparam int DEGREE    = 7;
    localparam int NUM_COEFS = 8;
    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 24;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int SUM_W     = PROD_W - FRAC_BITS + 1;
    localparam int CFG_IDX_W = $clog2(NUM_COEFS);
    localparam int LATENCY   = 2 * DEGREE;

    typedef logic signed [DATA_W-1:0] t_word;

    typedef struct packed {
        logic  valid;
        logic  sat;
        t_word acc;
        t_word x;
    } t_beat;

    function automatic logic sum_out_of_range(input logic signed [SUM_W-1:0] s);
        logic [SUM_W-DATA_W:0] top;
        top = s[SUM_W-1:DATA_W-1];
        return !((&top) || !(|top));
    endfunction

    function automatic t_word clip_sum(input logic signed [SUM_W-1:0] s);
        t_word r;
        if (!sum_out_of_range(s)) begin
            r = s[DATA_W-1:0];
        end else if (s[SUM_W-1]) begin
            r = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(DATA_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/horner_polynomial_eval_unit.sv @@
// ----------------------------------------------------------------------------
// horner_polynomial_eval_unit
// Degree-7 polynomial in signed Q8.24, Horner form, saturating per step.
// ----------------------------------------------------------------------------
// pipeline: two register stages per Horner step
// throughput: one point per cycle, busy never rises; the multiply and add
//   stages of each of the seven steps set the pipeline depth
// reset: synchronous active low, clears all valid bits and the coefficients
// the receiver cannot stall, each result beat shows for one cycle
module horner_polynomial_eval_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  hpe_pkg::t_word                i_point,
    input  logic                          i_cfg_we,
    input  logic [hpe_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  hpe_pkg::t_word                i_cfg_data,
    output logic                          o_done,
    output hpe_pkg::t_word                o_value,
    output logic                          o_saturated
);
    import hpe_pkg::*;

    t_word r_coef [NUM_COEFS];
    t_beat s_beat [DEGREE+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_COEFS; i++) begin
                r_coef[i] <= '0;
            end
        end else if (i_cfg_we) begin
            r_coef[i_cfg_idx] <= i_cfg_data;
        end
    end

    assign busy = 1'b0;

    always_comb begin
        s_beat[0].valid = start & ~busy;
        s_beat[0].sat   = 1'b0;
        s_beat[0].acc   = r_coef[DEGREE];
        s_beat[0].x     = i_point;
    end

    for (genvar k = 0; k < DEGREE; k++) begin : g_step
        hpe_step u_step (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_beat (s_beat[k]),
            .i_coef (r_coef[DEGREE-1-k]),
            .o_beat (s_beat[k+1])
        );
    end

    assign o_done      = s_beat[DEGREE].valid;
    assign o_value     = s_beat[DEGREE].acc;
    assign o_saturated = s_beat[DEGREE].sat;

    a_done_follows_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, LATENCY))
        else $error("result beat without a start beat at the pipeline latency");

    a_reset_clears_done: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result beat right after reset");

    a_start_reaches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##LATENCY o_done)
        else $error("start beat lost");

endmodule

@@ hw/rtl/hpe_step.sv @@
// ----------------------------------------------------------------------------
// hpe_step
// One Horner step over two stages: multiply, then shift, add and saturate.
// ----------------------------------------------------------------------------
module hpe_step (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  hpe_pkg::t_beat i_beat,
    input  hpe_pkg::t_word i_coef,
    output hpe_pkg::t_beat o_beat
);
    import hpe_pkg::*;

    logic                     r_valid_a;
    logic                     r_sat_a;
    t_word                    r_x_a;
    logic signed [PROD_W-1:0] r_prod;

    logic signed [PROD_W-1:0] n_prod;
    logic signed [SUM_W-1:0]  n_sum;

    t_beat r_out;

    assign n_prod = PROD_W'(i_beat.acc) * PROD_W'(i_beat.x);
    assign n_sum  = SUM_W'(r_prod >>> FRAC_BITS) + SUM_W'(i_coef);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a   <= 1'b0;
            r_out.valid <= 1'b0;
        end else begin
            r_valid_a   <= i_beat.valid;
            r_out.valid <= r_valid_a;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_sat_a   <= i_beat.sat;
        r_x_a     <= i_beat.x;
        r_prod    <= n_prod;
        r_out.sat <= r_sat_a | sum_out_of_range(n_sum);
        r_out.acc <= clip_sum(n_sum);
        r_out.x   <= r_x_a;
    end

    assign o_beat = r_out;

endmodule

@@ test/tb_horner_polynomial_eval_unit.sv @@
// ----------------------------------------------------------------------------
// tb_horner_polynomial_eval_unit
// Drives evaluation points into the Horner unit under randomized start gaps,
// predicts each saturated Q8.24 value and clip flag from a local copy of the
// coefficients, and checks every o_done beat in order against that prediction.
// ----------------------------------------------------------------------------
module tb_horner_polynomial_eval_unit;

    import hpe_pkg::*;

    localparam int     CYCLE_LIMIT  = 200000;
    localparam int     RAND_PHASES  = 10;
    localparam int     PHASE_POINTS = 95;
    localparam longint WORD_MAX_L   = 64'sd2147483647;
    localparam longint WORD_MIN_L   = -64'sd2147483648;
    localparam t_word  WORD_MAX     = 32'sh7fff_ffff;
    localparam t_word  WORD_MIN     = 32'sh8000_0000;
    localparam t_word  ONE_Q24      = 32'sh0100_0000;

    typedef struct {
        t_word value;
        logic  saturated;
    } t_poly_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    t_word                i_point;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    t_word                i_cfg_data;
    logic                 o_done;
    t_word                o_value;
    logic                 o_saturated;

    t_word        coef_model [NUM_COEFS];
    t_poly_result due_results[$];
    int           err_count;
    int           cycle_count;
    int           steady_left;

    horner_polynomial_eval_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_point     (i_point),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_done      (o_done),
        .o_value     (o_value),
        .o_saturated (o_saturated)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic t_poly_result horner_eval(input t_word x);
        t_poly_result r;
        longint       acc;
        longint       prod;
        acc = longint'(coef_model[DEGREE]);
        r.saturated = 1'b0;
        for (int i = DEGREE - 1; i >= 0; i--) begin
            prod = acc * longint'(x);
            acc  = (prod >>> FRAC_BITS) + longint'(coef_model[i]);
            if (acc > WORD_MAX_L) begin
                acc = WORD_MAX_L;
                r.saturated = 1'b1;
            end else if (acc < WORD_MIN_L) begin
                acc = WORD_MIN_L;
                r.saturated = 1'b1;
            end
        end
        r.value = t_word'(acc);
        return r;
    endfunction

    // half the draws are small magnitudes so results stay in range, the rest full range and rails
    function automatic t_word rand_word();
        int unsigned r;
        case ($urandom_range(0, 5))
            0: r = $urandom;
            1: r = WORD_MIN;
            2: r = WORD_MAX;
            default: r = $urandom_range(0, 2 * ONE_Q24) - ONE_Q24;
        endcase
        return t_word'(r);
    endfunction

    always @(posedge i_clk) begin
        t_poly_result want;
        if (i_rst_n && o_done) begin
            if (due_results.size() == 0) begin
                $error("o_done beat with no value due");
                err_count++;
            end else begin
                want = due_results.pop_front();
                if (o_value !== want.value) begin
                    $error("value: expected %h actual %h", want.value, o_value);
                    err_count++;
                end
                if (o_saturated !== want.saturated) begin
                    $error("saturated: expected %b actual %b", want.saturated, o_saturated);
                    err_count++;
                end
            end
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_point(input t_word x);
        int gap;
        if (steady_left > 0) begin
            gap = 0;
            steady_left--;
        end else if ($urandom_range(0, 15) == 0) begin
            gap = 0;
            steady_left = $urandom_range(10, 40);
        end else begin
            gap = $urandom_range(0, 8);
        end
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start   <= 1'b1;
        i_point <= x;
        do @(posedge i_clk); while (busy);
        due_results.push_back(horner_eval(x));
        @(negedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (due_results.size() != 0) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic load_coefs(input t_word vals[NUM_COEFS]);
        for (int i = 0; i < NUM_COEFS; i++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_IDX_W'(i);
            i_cfg_data <= vals[i];
            coef_model[i] = vals[i];
            @(negedge i_clk);
        end
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic test_reset_coefs();
        send_point(32'sd0);
        send_point(WORD_MAX);
        send_point(WORD_MIN);
        drain();
    endtask

    task automatic test_identity_and_floor();
        t_word c[NUM_COEFS];
        foreach (c[i]) c[i] = '0;
        c[1] = ONE_Q24;
        load_coefs(c);
        send_point(32'sd1);
        send_point(-32'sd1);
        send_point(WORD_MAX);
        send_point(WORD_MIN);
        drain();
        // negative products round toward minus infinity
        c[1] = -32'sd1;
        load_coefs(c);
        send_point(32'sd1);
        send_point(-32'sd1);
        drain();
    endtask

    task automatic test_saturation();
        t_word c[NUM_COEFS];
        foreach (c[i]) c[i] = WORD_MAX;
        load_coefs(c);
        send_point(WORD_MAX);
        send_point(WORD_MIN);
        send_point(32'sd0);
        drain();
        foreach (c[i]) c[i] = WORD_MIN;
        load_coefs(c);
        send_point(WORD_MAX);
        send_point(-ONE_Q24);
        drain();
        // clip in an early step, later steps come back in range, flag stays
        foreach (c[i]) c[i] = '0;
        c[7] = WORD_MAX;
        c[6] = WORD_MIN;
        c[5] = WORD_MIN;
        c[0] = 32'sd5;
        load_coefs(c);
        send_point(-ONE_Q24);
        send_point(ONE_Q24);
        drain();
    endtask

    task automatic test_random_points();
        t_word c[NUM_COEFS];
        for (int p = 0; p < RAND_PHASES; p++) begin
            foreach (c[i]) c[i] = rand_word();
            load_coefs(c);
            for (int n = 0; n < PHASE_POINTS; n++) send_point(rand_word());
            drain();
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_point     = '0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        err_count   = 0;
        cycle_count = 0;
        steady_left = 0;
        foreach (coef_model[i]) coef_model[i] = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_coefs();
        test_identity_and_floor();
        test_saturation();
        test_random_points();

        repeat (2 * LATENCY) @(negedge i_clk);
        if (due_results.size() != 0) begin
            $error("%0d values still due at end", due_results.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/hpe_pkg.sv
hw/rtl/hpe_step.sv
hw/rtl/horner_polynomial_eval_unit.sv
test/tb_horner_polynomial_eval_unit.sv
